// ----- rtl/table_search_engine_assert.svh -----
// assertion macros used by the search sequencer (tse_ctrl)
`ifndef TABLE_SEARCH_ENGINE_ASSERT_SVH
`define TABLE_SEARCH_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tse_pkg.sv -----
package tse_pkg;

  // default table depth
  localparam int TableDepthDef = 32;

  // field widths
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 5;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE  = 1'b1;

  // item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // search modes
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // result of the shared compare unit
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

// ----- rtl/tse_in_if.sv -----
interface tse_in_if;

  logic                                valid;
  logic                                ready;
  logic                                action;
  logic        [tse_pkg::IDX_W-1:0]    element_index;
  logic signed [tse_pkg::DATA_W-1:0]   element_value;
  logic signed [tse_pkg::DATA_W-1:0]   search_key;

  modport source (
    output valid, action, element_index, element_value, search_key,
    input  ready
  );

  modport sink (
    input  valid, action, element_index, element_value, search_key,
    output ready
  );

endinterface

// ----- rtl/tse_out_if.sv -----
interface tse_out_if;

  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [tse_pkg::IDX_W-1:0]    found_index;

  modport source (
    output valid, found, found_index,
    input  ready
  );

  modport sink (
    input  valid, found, found_index,
    output ready
  );

endinterface

// ----- rtl/tse_ram.sv -----
module tse_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/tse_cmp.sv -----
module tse_cmp (
  input  logic signed [tse_pkg::DATA_W-1:0] probe_i,
  input  logic signed [tse_pkg::DATA_W-1:0] key_i,
  output tse_pkg::cmp_res_t                 res_o
);

  // signed equality and greater-than of a table entry against the key
  always_comb begin
    res_o.eq = (probe_i == key_i);
    res_o.gt = (probe_i > key_i);
  end

endmodule

// ----- rtl/tse_ctrl.sv -----
`include "table_search_engine_assert.svh"

module tse_ctrl #(
  parameter int TableDepth = tse_pkg::TableDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [tse_pkg::LEN_W-1:0]         table_len_i,
  input  logic                              search_mode_i,
  tse_in_if.sink                            in_i,
  tse_out_if.source                         out_o,
  output logic                              ram_we_o,
  output logic [$clog2(TableDepth)-1:0]     ram_waddr_o,
  output logic [$clog2(TableDepth)-1:0]     ram_raddr_o,
  input  logic signed [tse_pkg::DATA_W-1:0] ram_rdata_i
);

  localparam int AW = $clog2(TableDepth);
  localparam int LW = (AW + 1 > tse_pkg::LEN_W) ? AW + 1 : tse_pkg::LEN_W;
  localparam int PW = AW + 2;
  localparam int IW = tse_pkg::IDX_W;

  tse_pkg::state_e state_q, state_d;

  logic        [AW-1:0]              idx_q, idx_d;
  logic        [AW-1:0]              last_q, last_d;
  logic signed [PW-1:0]              low_q, low_d;
  logic signed [PW-1:0]              high_q, high_d;
  logic signed [tse_pkg::DATA_W-1:0] key_q, key_d;
  logic                              mode_q, mode_d;
  logic                              found_q, found_d;
  logic        [AW-1:0]              fidx_q, fidx_d;

  logic [LW-1:0]        len_ext;
  logic [LW-1:0]        len_sat;
  logic [AW-1:0]        last_w;
  logic signed [PW-1:0] low_n, high_n, sum_n;
  logic                 in_acc;
  logic                 out_acc;
  logic                 load_ok;
  tse_pkg::cmp_res_t    cmp_res;

  // shared compare unit, one probe per cycle
  tse_cmp u_cmp (
    .probe_i (ram_rdata_i),
    .key_i   (key_q),
    .res_o   (cmp_res)
  );

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;

  // searched length clipped to the table depth
  assign len_ext = LW'(table_len_i);
  assign len_sat = (len_ext > LW'(TableDepth)) ? LW'(TableDepth) : len_ext;
  assign last_w  = AW'(len_sat - LW'(1));

  // bisection bounds after the current probe
  always_comb begin
    low_n  = low_q;
    high_n = high_q;
    if (cmp_res.gt) begin
      high_n = $signed({2'b00, idx_q}) - PW'(1);
    end else begin
      low_n = $signed({2'b00, idx_q}) + PW'(1);
    end
    sum_n = low_n + high_n;
  end

  assign load_ok = (32'(in_i.element_index) < 32'(TableDepth));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tse_pkg::ST_IDLE: begin
        if (in_acc && in_i.action == tse_pkg::ACT_QUERY) begin
          state_d = (len_sat == '0) ? tse_pkg::ST_RESP : tse_pkg::ST_SCAN;
        end
      end
      tse_pkg::ST_SCAN: begin
        if (cmp_res.eq) begin
          state_d = tse_pkg::ST_RESP;
        end else if (mode_q == tse_pkg::MODE_LINEAR) begin
          if (idx_q == last_q) begin
            state_d = tse_pkg::ST_RESP;
          end
        end else if (low_n > high_n) begin
          state_d = tse_pkg::ST_RESP;
        end
      end
      tse_pkg::ST_RESP: begin
        if (out_acc) begin
          state_d = tse_pkg::ST_IDLE;
        end
      end
      default: state_d = tse_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    idx_d   = idx_q;
    last_d  = last_q;
    low_d   = low_q;
    high_d  = high_q;
    key_d   = key_q;
    mode_d  = mode_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    unique case (state_q)
      tse_pkg::ST_IDLE: begin
        if (in_acc && in_i.action == tse_pkg::ACT_QUERY) begin
          key_d   = in_i.search_key;
          mode_d  = search_mode_i;
          last_d  = last_w;
          low_d   = '0;
          high_d  = $signed({2'b00, last_w});
          found_d = 1'b0;
          fidx_d  = '0;
          idx_d   = (search_mode_i == tse_pkg::MODE_BINARY) ? AW'(last_w >> 1) : '0;
        end
      end
      tse_pkg::ST_SCAN: begin
        if (cmp_res.eq) begin
          found_d = 1'b1;
          fidx_d  = idx_q;
        end else if (mode_q == tse_pkg::MODE_LINEAR) begin
          idx_d = idx_q + AW'(1);
        end else begin
          low_d  = low_n;
          high_d = high_n;
          idx_d  = sum_n[AW:1];
        end
      end
      tse_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // handshake and table write strobes
  always_comb begin
    in_i.ready  = (state_q == tse_pkg::ST_IDLE);
    out_o.valid = (state_q == tse_pkg::ST_RESP);
    ram_we_o    = in_acc && (in_i.action == tse_pkg::ACT_LOAD) && load_ok;
  end

  assign ram_waddr_o       = AW'(in_i.element_index);
  assign ram_raddr_o       = idx_d;
  assign out_o.found       = found_q;
  assign out_o.found_index = IW'(fidx_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tse_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // search context and result
  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    low_q   <= low_d;
    high_q  <= high_d;
    key_q   <= key_d;
    mode_q  <= mode_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
  end

  `TSE_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, state_q == tse_pkg::ST_SCAN,
                  idx_q <= last_q, "probe index beyond searched length")
  `TSE_ASSERT_IMP(a_bisect_bounds, clk_i, rst_ni,
                  state_q == tse_pkg::ST_SCAN && mode_q == tse_pkg::MODE_BINARY,
                  low_q <= $signed({2'b00, idx_q}) && $signed({2'b00, idx_q}) <= high_q,
                  "bisection probe outside bounds")
  `TSE_ASSERT_IMP(a_miss_index_zero, clk_i, rst_ni, out_o.valid && !out_o.found,
                  out_o.found_index == '0, "index not zero on a miss")
  `TSE_ASSERT_NXT(a_empty_query, clk_i, rst_ni,
                  in_acc && in_i.action == tse_pkg::ACT_QUERY && len_sat == '0,
                  state_q == tse_pkg::ST_RESP && !found_q, "empty table query not answered")

endmodule

// ----- rtl/table_search_engine.sv -----
// load transaction: written to the table on acceptance, no result
// query transaction: accepted, then the probes run (none for an empty table), then the result is held
// linear probes: up to min(table_length, TableDepth); binary: up to floor(log2 of that length) + 1
// the single table read port and compare unit set one probe per cycle
// a new transaction is taken once the result has been handed over
// reset zeroes state, index, config; table contents and search context undefined until loaded
module table_search_engine #(
  parameter int TableDepth = tse_pkg::TableDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tse_in_if.sink                           in_i,
  tse_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [tse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tse_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int AW = $clog2(TableDepth);

  logic [tse_pkg::LEN_W-1:0] table_len_q;
  logic                      search_mode_q;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             ram_raddr;
  logic [tse_pkg::DATA_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_len_q   <= '0;
      search_mode_q <= tse_pkg::MODE_LINEAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tse_pkg::CFG_TABLE_LENGTH: table_len_q   <= cfg_wdata_i[tse_pkg::LEN_W-1:0];
        tse_pkg::CFG_SEARCH_MODE:  search_mode_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // entry table
  tse_ram #(
    .Width (tse_pkg::DATA_W),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.element_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search sequencer
  tse_ctrl #(
    .TableDepth (TableDepth)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .table_len_i   (table_len_q),
    .search_mode_i (search_mode_q),
    .in_i          (in_i),
    .out_o         (out_o),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   ($signed(ram_rdata))
  );

endmodule
